@@ rtl/core/dpof_pkg.sv @@
`timescale 1ns / 1ps
package dpof_pkg;

    localparam int MAX_POINTS   = 2048;
    localparam int COORD_BITS   = 16;
    localparam int COUNT_W      = 12;
    localparam int DIST_W       = 32;
    localparam int TARGET_W     = 12;

    // The point table is striped over the cells: point k lives in cell k % NUM_CELLS
    // at word k / NUM_CELLS.
    localparam int NUM_CELLS    = 4;
    localparam int CELL_IDX_W   = $clog2(NUM_CELLS);
    localparam int BANK_DEPTH   = MAX_POINTS / NUM_CELLS;
    localparam int BANK_AW      = $clog2(BANK_DEPTH);

    localparam logic [DIST_W-1:0]   MIN_DIST_RESET = DIST_W'(6711);
    localparam logic [TARGET_W-1:0] TARGET_RESET   = TARGET_W'(2037);

    // Register indexes on the config port.
    localparam logic CFG_MIN_DIST = 1'b0;
    localparam logic CFG_TARGET   = 1'b1;

    // Token moving down the chain: one bank word per beat.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [BANK_AW-1:0] addr;
        logic               hit;
    } t_tok;

    // Table write request, one point.
    typedef struct packed {
        logic                  en;
        logic [CELL_IDX_W-1:0] bank;
        logic [BANK_AW-1:0]    addr;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_wr;

endpackage

@@ rtl/core/dpof_cell.sv @@
`timescale 1ns / 1ps
module dpof_cell
    import dpof_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CELL_IDX_W-1:0] i_cell_idx,
    input  t_tok                  i_tok,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic [DIST_W-1:0]     i_thr,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic                  i_we,
    input  logic [BANK_AW-1:0]    i_wr_addr,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    output t_tok                  o_tok
);

    logic [2*COORD_BITS-1:0] r_mem [BANK_DEPTH];
    logic [2*COORD_BITS-1:0] r_rd;

    t_tok r_tok1, r_tok2, r_tok3;
    t_tok n_tok3;
    logic r_live1, r_live2;

    logic [COORD_BITS-1:0]   rd_x, rd_y, dx, dy;
    logic [2*COORD_BITS-1:0] r_sx, r_sy;
    logic [2*COORD_BITS:0]   sum;
    logic                    near;

    // bank write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
    end

    // stage 1: bank read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_tok.addr];
    end

    assign rd_x = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign rd_y = r_rd[COORD_BITS-1:0];
    assign dx   = (i_cand_x > rd_x) ? (i_cand_x - rd_x) : (rd_x - i_cand_x);
    assign dy   = (i_cand_y > rd_y) ? (i_cand_y - rd_y) : (rd_y - i_cand_y);

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        r_sx <= (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
        r_sy <= (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    end

    assign sum  = {1'b0, r_sx} + {1'b0, r_sy};
    assign near = sum < {1'b0, i_thr};

    always_comb begin
        n_tok3     = r_tok2;
        n_tok3.hit = r_tok2.hit | (r_live2 & near);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1  <= '0;
            r_tok2  <= '0;
            r_tok3  <= '0;
            r_live1 <= 1'b0;
            r_live2 <= 1'b0;
        end else begin
            r_tok1  <= i_tok;
            // only stored entries take part
            r_live1 <= i_tok.valid && (COUNT_W'({i_tok.addr, i_cell_idx}) < i_count);
            r_tok2  <= r_tok1;
            r_live2 <= r_live1;
            r_tok3  <= n_tok3;
        end
    end

    assign o_tok = r_tok3;

endmodule

@@ rtl/core/dpof_chain.sv @@
`timescale 1ns / 1ps
module dpof_chain
    import dpof_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tok                  i_tok,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic [DIST_W-1:0]     i_thr,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  t_wr                   i_wr,
    output t_tok                  o_tok
);

    t_tok w_tok [NUM_CELLS+1];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        dpof_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (CELL_IDX_W'(g)),
            .i_tok      (w_tok[g]),
            .i_count    (i_count),
            .i_thr      (i_thr),
            .i_cand_x   (i_cand_x),
            .i_cand_y   (i_cand_y),
            .i_we       (i_wr.en && (i_wr.bank == CELL_IDX_W'(g))),
            .i_wr_addr  (i_wr.addr),
            .i_wr_x     (i_wr.x),
            .i_wr_y     (i_wr.y),
            .o_tok      (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[NUM_CELLS];

endmodule

@@ rtl/core/disk_placement_overlap_filter.sv @@
`timescale 1ns / 1ps
// Overlap filter for dart-throwing disk placement.
// Input: one candidate point per beat on i_cand_x / i_cand_y, taken at a
// rising edge with start high and busy low. busy stays high until the
// result beat has been issued.
// Output: one result beat per candidate, o_done high for exactly one cycle
// with o_accepted, o_placed_count and o_full_res. The receiver cannot stall;
// a result beat is gone after its cycle.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data, index 0 is the squared
// exclusion distance, index 1 the target point count. Write only while idle.
// Structure: the stored points are striped over a chain of 4 cells, each with
// its own bank. One bank word (4 points) enters the chain per cycle, and a
// candidate's result is decided when the last word leaves the chain. With an
// empty or full table there is no sweep: the result is decided in the issue
// state. The block takes no new candidate while one is in flight: the next
// start is taken at the edge that takes the result.
// Reset: stored count cleared, registers to their defaults. The bank
// contents are not cleared; entries past the count are never compared.
module disk_placement_overlap_filter
    import dpof_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_cand_x,
    input  logic [COORD_BITS-1:0] i_cand_y,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [DIST_W-1:0]     i_cfg_data,
    output logic                  o_done,
    output logic                  o_accepted,
    output logic [COUNT_W-1:0]    o_placed_count,
    output logic                  o_full_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]            r_state;
    logic [DIST_W-1:0]     r_min_dist_sq;
    logic [TARGET_W-1:0]   r_target;
    logic [COUNT_W-1:0]    r_count;
    logic [COORD_BITS-1:0] r_cand_x, r_cand_y;
    logic [BANK_AW-1:0]    r_addr;
    logic                  r_hit;
    t_tok                  r_inj;

    t_tok                  chain_out;
    t_wr                   wr;
    logic [COUNT_W-1:0]    target_eff;
    logic [COUNT_W-1:0]    cnt_m1;
    logic [BANK_AW-1:0]    last_addr;
    logic                  tab_full;
    logic                  commit;
    logic                  reject;
    logic [COUNT_W-1:0]    cnt_inc;

    // target saturates at the table depth
    assign target_eff = (r_target > TARGET_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS)
                                                          : COUNT_W'(r_target);
    assign tab_full   = r_count >= target_eff;
    assign cnt_m1     = r_count - COUNT_W'(1);
    assign last_addr  = cnt_m1[CELL_IDX_W +: BANK_AW];
    assign cnt_inc    = r_count + COUNT_W'(1);

    // store on an empty table that is not full, or when the sweep saw no overlap
    assign commit = ((r_state == S_ISSUE) && !tab_full && (r_count == '0))
                 || ((r_state == S_WAIT) && chain_out.valid && chain_out.last
                     && !(r_hit | chain_out.hit));
    assign reject = ((r_state == S_ISSUE) && tab_full)
                 || ((r_state == S_WAIT) && chain_out.valid && chain_out.last
                     && (r_hit | chain_out.hit));

    assign wr.en   = commit;
    assign wr.bank = r_count[CELL_IDX_W-1:0];
    assign wr.addr = r_count[CELL_IDX_W +: BANK_AW];
    assign wr.x    = r_cand_x;
    assign wr.y    = r_cand_y;

    assign busy = (r_state != S_IDLE);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist_sq <= MIN_DIST_RESET;
            r_target      <= TARGET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_DIST: r_min_dist_sq <= i_cfg_data;
                CFG_TARGET:   r_target      <= i_cfg_data[TARGET_W-1:0];
                default:      ;
            endcase
        end
    end

    // candidate hold
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cand_x <= i_cand_x;
            r_cand_y <= i_cand_y;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        o_accepted     <= commit;
        o_placed_count <= commit ? cnt_inc : r_count;
        o_full_res     <= commit ? (cnt_inc >= target_eff) : tab_full;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_hit   <= 1'b0;
            r_inj   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= commit | reject;
            if (commit) begin
                r_count <= cnt_inc;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    r_hit  <= 1'b0;
                    r_inj  <= '0;
                    if (start) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    // on a long table the first words leave the chain while
                    // later ones are still going in
                    if (chain_out.valid) begin
                        r_hit <= r_hit | chain_out.hit;
                    end
                    if (commit || reject) begin
                        r_inj   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        // one bank word per cycle into the chain
                        r_inj  <= '{valid: 1'b1, last: (r_addr == last_addr),
                                    addr: r_addr, hit: 1'b0};
                        r_addr <= r_addr + BANK_AW'(1);
                        if (r_addr == last_addr) begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    r_inj <= '0;
                    if (chain_out.valid) begin
                        r_hit <= r_hit | chain_out.hit;
                    end
                    if (commit || reject) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    dpof_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (r_inj),
        .i_count  (r_count),
        .i_thr    (r_min_dist_sq),
        .i_cand_x (r_cand_x),
        .i_cand_y (r_cand_y),
        .i_wr     (wr),
        .o_tok    (chain_out)
    );

    // a result beat never follows another directly
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result beats");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_POINTS))
        else $error("point count past table depth");

    a_chain_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_out.valid |-> (r_state != S_IDLE))
        else $error("chain output outside sweep");

    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_accepted) |-> (r_count == COUNT_W'($past(r_count) + 1)))
        else $error("accepted result without count step");

    a_no_store_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_count < target_eff))
        else $error("store into full table");

endmodule
